// ===== rtl/nimlc_pkg.sv =====
// ----------------------------------------------------------------------------
// nimlc_pkg
// Shared types and codes for the nested interrupt mask level controller.
// ----------------------------------------------------------------------------
package nimlc_pkg;

	typedef enum logic [1:0] {
		K_DISABLE   = 2'd0,
		K_ENABLE    = 2'd1,
		K_INCREMENT = 2'd2,
		K_DECREMENT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ENABLE_ZERO = 3'd1,
		ST_INC_NONZERO = 3'd2,
		ST_DEC_NOT_ONE = 3'd3,
		ST_SATURATED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_EXEC   = 2'd1,
		S_REPORT = 2'd2
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	localparam int unsigned KIND_W   = 2;
	localparam int unsigned LEVEL_W  = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 8;

endpackage

// ===== rtl/nested_irq_mask_level_control.sv =====
// ----------------------------------------------------------------------------
// nested_irq_mask_level_control
// Per-level interrupt disable nesting counters with mask level rewrite.
// Sequencing: an accepted start moves through S_EXEC to S_REPORT, which raises done.
// A new request is not taken while busy (S_EXEC); one is taken in the
// cycle its predecessor reports.
// Reset: all nesting counters clear to zero, sequencer returns to idle.
// Results are presented for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module nested_irq_mask_level_control #(
	parameter int unsigned LEVELS     = 8,
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [nimlc_pkg::KIND_W-1:0]   kind,
	input  logic [nimlc_pkg::LEVEL_W-1:0]  level,
	output logic                           done,
	output logic                           mask_write,
	output logic [nimlc_pkg::LEVEL_W-1:0]  mask_level,
	output logic [nimlc_pkg::STATUS_W-1:0] status,
	output logic [nimlc_pkg::COUNT_W-1:0]  count_after
);
	import nimlc_pkg::*;

	cmd_t cmd;

	nimlc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	nimlc_dp #(
		.LEVELS     (LEVELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.level       (level),
		.mask_write  (mask_write),
		.mask_level  (mask_level),
		.status      (status),
		.count_after (count_after)
	);

endmodule

// ===== rtl/nimlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// nimlc_ctrl
// Request sequencer: capture, execute, report.
// ----------------------------------------------------------------------------
module nimlc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output nimlc_pkg::cmd_t cmd
);
	import nimlc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				if (accept) begin
					state_d = S_EXEC;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		done     = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			S_REPORT: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
		cmd.load = start && !busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/nimlc_dp.sv =====
// ----------------------------------------------------------------------------
// nimlc_dp
// Nesting counters, request update logic and mask level priority encoder.
// ----------------------------------------------------------------------------
module nimlc_dp #(
	parameter int unsigned LEVELS     = 8,
	parameter int unsigned COUNT_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nimlc_pkg::cmd_t                cmd,
	input  logic [nimlc_pkg::KIND_W-1:0]   kind,
	input  logic [nimlc_pkg::LEVEL_W-1:0]  level,
	output logic                           mask_write,
	output logic [nimlc_pkg::LEVEL_W-1:0]  mask_level,
	output logic [nimlc_pkg::STATUS_W-1:0] status,
	output logic [nimlc_pkg::COUNT_W-1:0]  count_after
);
	import nimlc_pkg::*;

	localparam int unsigned IDX_W = (LEVELS > 2) ? $clog2(LEVELS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
	localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

	logic [COUNT_BITS-1:0] counts_q [LEVELS];
	logic [KIND_W-1:0]     kind_q;
	logic [LEVEL_W-1:0]    level_q;

	logic                  wr_q;
	logic [STATUS_W-1:0]   status_q;
	logic [COUNT_W-1:0]    count_q;

	logic [31:0]           level_wide;
	logic [IDX_W-1:0]      idx;
	logic                  in_range;
	logic [COUNT_BITS-1:0] c_cur;
	logic [COUNT_BITS-1:0] c_new;
	logic                  wr_d;
	status_t               st_d;
	logic [31:0]           c_wide;
	logic [LEVELS-1:0]     nonzero;
	logic [IDX_W-1:0]      top;

	assign level_wide = {{(32 - LEVEL_W){1'b0}}, level_q};
	assign idx        = level_wide[IDX_W-1:0];
	assign in_range   = (level_q != '0) && (level_wide < LEVELS);
	assign c_cur      = counts_q[idx];

	always_comb begin
		c_new = c_cur;
		wr_d  = 1'b0;
		st_d  = ST_OK;
		case (kind_t'(kind_q))
			K_DISABLE: begin
				if (c_cur == CNT_MAX) begin
					st_d = ST_SATURATED;
				end else begin
					wr_d  = (c_cur == CNT_ZERO);
					c_new = c_cur + CNT_ONE;
				end
			end
			K_ENABLE: begin
				if (c_cur == CNT_ZERO) begin
					st_d = ST_ENABLE_ZERO;
				end else begin
					wr_d  = (c_cur == CNT_ONE);
					c_new = c_cur - CNT_ONE;
				end
			end
			K_INCREMENT: begin
				if (c_cur != CNT_ZERO) begin
					st_d = ST_INC_NONZERO;
				end else begin
					c_new = CNT_ONE;
				end
			end
			default: begin
				if (c_cur != CNT_ONE) begin
					st_d = ST_DEC_NOT_ONE;
				end else begin
					c_new = CNT_ZERO;
				end
			end
		endcase
	end

	assign c_wide = 32'(c_new);

	// Highest nonzero level; level zero never takes part
	always_comb begin
		top = '0;
		for (int i = 0; i < LEVELS; i++) begin
			nonzero[i] = (counts_q[i] != CNT_ZERO);
		end
		for (int i = 1; i < LEVELS; i++) begin
			if (nonzero[i]) begin
				top = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			level_q <= level;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			wr_q     <= in_range && wr_d;
			status_q <= in_range ? st_d : ST_OK;
			count_q  <= in_range ? c_wide[COUNT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (cmd.exec && in_range) begin
			counts_q[idx] <= c_new;
		end
	end

	assign mask_write  = wr_q;
	assign status      = status_q;
	assign count_after = count_q;
	assign mask_level  = LEVEL_W'(32'(top));

endmodule

// ===== rtl/nimlc_checker.sv =====
// ----------------------------------------------------------------------------
// nimlc_checker
// Port-level checks on request sequencing and result consistency.
// ----------------------------------------------------------------------------
module nimlc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           mask_write,
	input logic [nimlc_pkg::STATUS_W-1:0] status,
	input logic [nimlc_pkg::COUNT_W-1:0]  count_after
);
	import nimlc_pkg::*;

	// Accepted request goes to work in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// Work cycle always ends in a report
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("busy cycle not followed by a result");

	// A result only follows a work cycle
	a_done_past: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without request");

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		done && mask_write |-> status == ST_OK)
		else $error("mask written on failed request");

	a_enable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ENABLE_ZERO |-> count_after == '0)
		else $error("enable at zero reported nonzero count");

endmodule

bind nested_irq_mask_level_control nimlc_checker u_nimlc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.mask_write  (mask_write),
	.status      (status),
	.count_after (count_after)
);

// ===== tb/tb_nested_irq_mask_level_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_irq_mask_level_control
// Drives disable, enable, increment and decrement requests into the nesting
// counter block and checks every reported mask update, status and count
// against a local model of the per-level counters and the priority search.
// ----------------------------------------------------------------------------
module tb_nested_irq_mask_level_control;

	import nimlc_pkg::*;

	localparam int unsigned N_LEVELS   = 8;
	localparam int unsigned CNT_BITS   = 8;
	localparam int unsigned CNT_MAX    = (1 << CNT_BITS) - 1;
	localparam int unsigned STALL_MAX  = 2000;
	localparam int unsigned RAND_BLOCKS = 14;
	localparam int unsigned BLOCK_LEN  = 100;

	typedef struct {
		logic                mask_write;
		logic [LEVEL_W-1:0]  mask_level;
		status_t             status;
		logic [COUNT_W-1:0]  count_after;
	} mask_update_t;

	class irq_mask_scoreboard;
		logic [CNT_BITS-1:0] nest_cnt [N_LEVELS];
		mask_update_t        pending_updates [$];
		int                  errors;

		function new();
			foreach (nest_cnt[i])
				nest_cnt[i] = '0;
			errors = 0;
		endfunction

		function logic [LEVEL_W-1:0] highest_level();
			for (int l = N_LEVELS - 1; l > 0; l--)
				if (nest_cnt[l] != 0)
					return LEVEL_W'(l);
			return '0;
		endfunction

		// Apply one accepted request to the counters and queue what it reports.
		function void note_request(kind_t k, logic [LEVEL_W-1:0] lv);
			mask_update_t        upd;
			logic [CNT_BITS-1:0] c;
			upd.mask_write  = 1'b0;
			upd.status      = ST_OK;
			upd.count_after = '0;
			if (lv != 0 && lv < N_LEVELS) begin
				c = nest_cnt[lv];
				case (k)
					K_DISABLE: begin
						if (c == CNT_MAX) begin
							upd.status = ST_SATURATED;
						end else begin
							if (c == 0)
								upd.mask_write = 1'b1;
							c = c + 1'b1;
						end
					end
					K_ENABLE: begin
						if (c == 0) begin
							upd.status = ST_ENABLE_ZERO;
						end else begin
							c = c - 1'b1;
							if (c == 0)
								upd.mask_write = 1'b1;
						end
					end
					K_INCREMENT: begin
						if (c != 0)
							upd.status = ST_INC_NONZERO;
						else
							c = CNT_BITS'(1);
					end
					default: begin
						if (c != 1)
							upd.status = ST_DEC_NOT_ONE;
						else
							c = '0;
					end
				endcase
				nest_cnt[lv]    = c;
				upd.count_after = COUNT_W'(c);
			end
			upd.mask_level = highest_level();
			pending_updates.push_back(upd);
		endfunction

		function void check_update(logic w, logic [LEVEL_W-1:0] ml,
				logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] ca);
			mask_update_t upd;
			if (pending_updates.size() == 0) begin
				$display("%0t: result with nothing expected (w=%0d lvl=%0d st=%0d cnt=%0d)",
					$time, w, ml, st, ca);
				errors++;
				return;
			end
			upd = pending_updates.pop_front();
			if (w !== upd.mask_write) begin
				$display("%0t: mask_write expected %0d actual %0d", $time, upd.mask_write, w);
				errors++;
			end
			if (ml !== upd.mask_level) begin
				$display("%0t: mask_level expected %0d actual %0d", $time, upd.mask_level, ml);
				errors++;
			end
			if (st !== upd.status) begin
				$display("%0t: status expected %0d actual %0d", $time, upd.status, st);
				errors++;
			end
			if (ca !== upd.count_after) begin
				$display("%0t: count_after expected %0d actual %0d", $time,
					upd.count_after, ca);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_updates.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [KIND_W-1:0]   kind;
	logic [LEVEL_W-1:0]  level;
	logic                done;
	logic                mask_write;
	logic [LEVEL_W-1:0]  mask_level;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count_after;

	irq_mask_scoreboard sb = new();
	int unsigned        stall_cycles;
	bit                 bias_up;
	bit                 gaps_on;

	nested_irq_mask_level_control #(
		.LEVELS     (N_LEVELS),
		.COUNT_BITS (CNT_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.level       (level),
		.done        (done),
		.mask_write  (mask_write),
		.mask_level  (mask_level),
		.status      (status),
		.count_after (count_after)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Track accepted requests and results; stop the run if nothing moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(kind_t'(kind), level);
			if (done)
				sb.check_update(mask_write, mask_level, status, count_after);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_MAX) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Hold one request until it is taken, then idle for the given gap.
	task automatic send_request(kind_t k, logic [LEVEL_W-1:0] lv, int unsigned gap);
		start <= 1'b1;
		kind  <= k;
		level <= lv;
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and wait until every queued update has been reported.
	task automatic drain_updates();
		start <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() > 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		kind_t             k;
		logic [LEVEL_W-1:0] lv;
		int unsigned       r;
		r = $urandom_range(0, 99);
		if (r < 42)
			k = bias_up ? K_DISABLE : K_ENABLE;
		else if (r < 78)
			k = bias_up ? K_ENABLE : K_DISABLE;
		else if (r < 89)
			k = K_INCREMENT;
		else
			k = K_DECREMENT;
		lv = ($urandom_range(0, 15) == 0) ? '0 : LEVEL_W'($urandom_range(1, N_LEVELS - 1));
		send_request(k, lv, pick_gap());
	endtask

	initial begin
		logic [LEVEL_W-1:0] sat_lvl;
		arst_n  = 1'b0;
		start   = 1'b0;
		kind    = K_DISABLE;
		level   = '0;
		gaps_on = 1'b1;
		bias_up = 1'b1;
		stall_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ignored level, then errors on empty counters
		send_request(K_DISABLE,   3'd0, 0);
		send_request(K_ENABLE,    3'd0, 1);
		send_request(K_INCREMENT, 3'd0, 0);
		send_request(K_DECREMENT, 3'd0, 2);
		send_request(K_ENABLE,    3'd7, 0);
		send_request(K_DECREMENT, 3'd7, 0);
		// Increment/decrement pair leaves the mask alone
		send_request(K_INCREMENT, 3'd7, 1);
		send_request(K_INCREMENT, 3'd7, 0);
		send_request(K_DECREMENT, 3'd7, 0);
		// Nesting across levels moves the mask up and back down
		send_request(K_DISABLE,   3'd1, 0);
		send_request(K_DISABLE,   3'd7, 3);
		send_request(K_DISABLE,   3'd7, 0);
		send_request(K_DISABLE,   3'd3, 0);
		send_request(K_ENABLE,    3'd7, 1);
		send_request(K_ENABLE,    3'd7, 0);
		send_request(K_ENABLE,    3'd3, 0);
		send_request(K_ENABLE,    3'd1, 0);
		send_request(K_INCREMENT, 3'd5, 0);
		send_request(K_DISABLE,   3'd5, 0);
		send_request(K_DECREMENT, 3'd5, 2);
		send_request(K_ENABLE,    3'd5, 0);
		send_request(K_ENABLE,    3'd5, 0);
		send_request(K_DISABLE,   3'd6, 0);
		send_request(K_DISABLE,   3'd2, 0);
		send_request(K_DISABLE,   3'd4, 0);
		drain_updates();

		// Run one level into saturation and back down to zero, then one enable at zero
		sat_lvl = LEVEL_W'($urandom_range(1, N_LEVELS - 1));
		repeat (CNT_MAX + 1)
			send_request(K_DISABLE, sat_lvl, pick_gap());
		repeat (CNT_MAX + 1)
			send_request(K_ENABLE, sat_lvl, pick_gap());

		for (int b = 0; b < RAND_BLOCKS; b++) begin
			bias_up = (b % 2 == 0);
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat (BLOCK_LEN)
				send_random();
			if (b % 4 == 1)
				drain_updates();
		end

		drain_updates();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
